@@ hw/rtl/wall_follow_mode_controller_core_defines.svh @@
// assertion macros for the wall follow controller checker
// each macro expects clk and rst_n in scope at the point of use
`ifndef WALL_FOLLOW_MODE_CONTROLLER_CORE_DEFINES_SVH
`define WALL_FOLLOW_MODE_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define WFMC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfmc same-cycle check failed");

// next-cycle implication, off during reset
`define WFMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wfmc next-cycle check failed");

// what must hold in the cycle after reset is seen
`define WFMC_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("wfmc reset check failed");

`endif

@@ hw/rtl/wfmc_pkg.sv @@
package wfmc_pkg;

  localparam int RANGE_W       = 16;
  localparam int LIN_W         = 9;
  localparam int TURN_W        = 11;
  localparam int MODE_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 23;
  localparam int SCAN_PTS_W    = 13;
  localparam int ANGLE_START_W = 23;
  localparam int ANGLE_STEP_W  = 17;
  localparam int TICK_W        = 16;
  localparam int BEAR_W        = 32;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_POINTS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CEILING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_STOP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_FAR       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_NEAR      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MANEUVER_TICKS = 3'd7;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_ORIENT      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPROACH    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALIGN_START = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ALIGN       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FOLLOW      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CORNER      = 3'd5;
  localparam logic [MODE_W-1:0] MODE_GOAL        = 3'd6;

  // orientation tolerance, microradians
  localparam logic signed [BEAR_W-1:0] ORIENT_TOL = 32'sd30000;

  // commands
  localparam logic [LIN_W-1:0]         V_APPROACH = 9'd500;
  localparam logic [LIN_W-1:0]         V_FOLLOW   = 9'd210;
  localparam logic signed [TURN_W-1:0] W_ORIENT   = 11'sd500;
  localparam logic signed [TURN_W-1:0] W_ALIGN    = -11'sd530;
  localparam logic signed [TURN_W-1:0] W_TOWARD   = 11'sd410;
  localparam logic signed [TURN_W-1:0] W_AWAY     = -11'sd410;
  localparam logic signed [TURN_W-1:0] W_CORNER   = -11'sd520;

  // reset values of the configuration registers
  localparam logic [SCAN_PTS_W-1:0]           RST_SCAN_POINTS    = 13'd720;
  localparam logic signed [ANGLE_START_W-1:0] RST_ANGLE_START    = -23'sd1570796;
  localparam logic [ANGLE_STEP_W-1:0]         RST_ANGLE_STEP     = 17'd4363;
  localparam logic [RANGE_W-1:0]              RST_RANGE_CEILING  = 16'd30000;
  localparam logic [RANGE_W-1:0]              RST_FRONT_STOP     = 16'd450;
  localparam logic [RANGE_W-1:0]              RST_WALL_FAR       = 16'd510;
  localparam logic [RANGE_W-1:0]              RST_WALL_NEAR      = 16'd490;
  localparam logic [TICK_W-1:0]               RST_MANEUVER_TICKS = 16'd300;

  typedef struct packed {
    logic [SCAN_PTS_W-1:0]           scan_points;
    logic signed [ANGLE_START_W-1:0] angle_start;
    logic [ANGLE_STEP_W-1:0]         angle_step;
    logic [RANGE_W-1:0]              range_ceiling;
    logic [RANGE_W-1:0]              front_stop;
    logic [RANGE_W-1:0]              wall_far;
    logic [RANGE_W-1:0]              wall_near;
    logic [TICK_W-1:0]               maneuver_ticks;
  } cfg_t;

  // one classified item as it travels through the queue
  typedef struct packed {
    logic               is_tick;
    logic               goal;
    logic               is_first;
    logic               is_mid;
    logic               is_last;
    logic [RANGE_W-1:0] range_mm;
  } item_t;

endpackage

@@ hw/rtl/wfmc_fifo.sv @@
module wfmc_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0]                       mem_r [wfmc_pkg::QUEUE_DEPTH];
  logic [wfmc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [wfmc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [wfmc_pkg::QUEUE_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                                do_push, do_pop;

  assign full     = (cnt_r == wfmc_pkg::QUEUE_CNT_W'(wfmc_pkg::QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;

  // depth is a power of two, so pointers wrap by themselves
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/wfmc_front.sv @@
module wfmc_front #(
  parameter int MAX_POINTS = 4096,
  parameter int IDX_W      = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [wfmc_pkg::RANGE_W-1:0]        in_range_mm,
  input  logic                                in_goal_visible,
  input  logic [wfmc_pkg::SCAN_PTS_W-1:0]     scan_points,
  input  logic                                q_full,
  output logic                                q_push,
  output wfmc_pkg::item_t                     q_item,
  output logic [IDX_W-1:0]                    q_idx
);

  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NW > wfmc_pkg::SCAN_PTS_W) ? NW : wfmc_pkg::SCAN_PTS_W;
  localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CW-1:0]    pts_ext, n_eff, last_idx, mid_idx, idx_ext;
  logic             is_last, take_sample;

  // clamp scan length to 2..MAX_POINTS
  always_comb begin
    pts_ext = CW'(scan_points);
    if (pts_ext < CW'(2)) begin
      n_eff = CW'(2);
    end else if (pts_ext > MAXP) begin
      n_eff = MAXP;
    end else begin
      n_eff = pts_ext;
    end
    last_idx = n_eff - CW'(1);
    mid_idx  = n_eff >> 1;
    idx_ext  = CW'(idx_r);
  end

  assign in_ready    = ~q_full;
  assign q_push      = in_valid & in_ready;
  assign take_sample = q_push & ~in_op;
  assign is_last     = (idx_ext >= last_idx);

  always_comb begin
    q_item.is_tick  = in_op;
    q_item.goal     = in_goal_visible;
    q_item.is_first = (idx_r == '0);
    q_item.is_mid   = (idx_ext == mid_idx);
    q_item.is_last  = is_last;
    q_item.range_mm = in_range_mm;
    q_idx           = idx_r;
  end

  // index past the last sample (length lowered mid-scan) still ends the scan
  always_comb begin
    idx_nxt = idx_r;
    if (take_sample) begin
      idx_nxt = is_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ hw/rtl/wfmc_back.sv @@
module wfmc_back #(
  parameter int IDX_W = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wfmc_pkg::cfg_t                      cfg,
  input  logic                                q_valid,
  input  wfmc_pkg::item_t                     q_item,
  input  logic [IDX_W-1:0]                    q_idx,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wfmc_pkg::LIN_W-1:0]          out_linear_mm_s,
  output logic signed [wfmc_pkg::TURN_W-1:0]  out_turn_mrad_s,
  output logic [wfmc_pkg::MODE_W-1:0]         out_mode
);

  localparam int PROD_W = IDX_W + wfmc_pkg::ANGLE_STEP_W;
  localparam int SUM_W  = PROD_W + 2;

  // scan state
  logic [wfmc_pkg::RANGE_W-1:0]       run_min_r, run_min_nxt;
  logic [IDX_W-1:0]                   min_idx_r, min_idx_nxt;
  logic [wfmc_pkg::RANGE_W-1:0]       front_r, front_nxt;
  logic [wfmc_pkg::RANGE_W-1:0]       left_r, left_nxt;
  logic signed [wfmc_pkg::BEAR_W-1:0] bear_r, bear_nxt;
  // bearing pipeline
  logic                               bidx_v_r;
  logic [IDX_W-1:0]                   bidx_r;
  logic                               prod_v_r;
  logic [PROD_W-1:0]                  prod_r;
  logic signed [SUM_W-1:0]            bear_sum;
  logic signed [wfmc_pkg::BEAR_W-1:0] bear_sat;
  // mode machine
  logic [wfmc_pkg::MODE_W-1:0]        mode_r, mode_nxt, mode_step;
  logic [wfmc_pkg::TICK_W-1:0]        count_r, count_nxt, count_step;
  logic [wfmc_pkg::LIN_W-1:0]         lin_step;
  logic signed [wfmc_pkg::TURN_W-1:0] turn_step;
  logic                               blocked;
  // output register
  logic                               out_valid_r, out_valid_nxt;
  logic [wfmc_pkg::LIN_W-1:0]         out_lin_r;
  logic signed [wfmc_pkg::TURN_W-1:0] out_turn_r;
  logic [wfmc_pkg::MODE_W-1:0]        out_mode_r;
  // control
  logic                               bear_busy, out_free, samp_go, tick_go;
  logic [wfmc_pkg::RANGE_W-1:0]       min_base;
  logic [IDX_W-1:0]                   idx_base;

  assign bear_busy = bidx_v_r | prod_v_r;
  assign out_free  = ~out_valid_r | out_ready;
  // ticks wait for a free output slot and a settled bearing
  assign q_pop     = q_valid & (~q_item.is_tick | (out_free & ~bear_busy));
  assign samp_go   = q_pop & ~q_item.is_tick;
  assign tick_go   = q_pop & q_item.is_tick;

  // running minimum, restarted on the first sample of a scan
  always_comb begin
    min_base    = q_item.is_first ? cfg.range_ceiling : run_min_r;
    idx_base    = q_item.is_first ? '0 : min_idx_r;
    run_min_nxt = run_min_r;
    min_idx_nxt = min_idx_r;
    front_nxt   = front_r;
    left_nxt    = left_r;
    if (samp_go) begin
      run_min_nxt = min_base;
      min_idx_nxt = idx_base;
      if (q_item.range_mm < min_base) begin
        run_min_nxt = q_item.range_mm;
        min_idx_nxt = q_idx;
      end
      if (q_item.is_mid) begin
        front_nxt = q_item.range_mm;
      end
      if (q_item.is_last) begin
        left_nxt = q_item.range_mm;
      end
    end
  end

  assign bear_sum = SUM_W'(cfg.angle_start) + SUM_W'($signed({1'b0, prod_r}));

  generate
    if (SUM_W > wfmc_pkg::BEAR_W) begin : g_sat
      localparam logic signed [SUM_W-1:0] BMAX = SUM_W'(64'sd2147483647);
      // the start value cannot push the sum below the negative limit
      assign bear_sat = (bear_sum > BMAX) ? wfmc_pkg::BEAR_W'(BMAX)
                                          : wfmc_pkg::BEAR_W'(bear_sum);
    end else begin : g_nosat
      assign bear_sat = wfmc_pkg::BEAR_W'(bear_sum);
    end
  endgenerate

  assign bear_nxt = prod_v_r ? bear_sat : bear_r;

  // mode step for one tick
  always_comb begin
    mode_step  = mode_r;
    count_step = count_r;
    lin_step   = '0;
    turn_step  = '0;
    blocked    = (front_r <= cfg.front_stop);
    unique case (mode_r)
      wfmc_pkg::MODE_ORIENT: begin
        if (bear_r > wfmc_pkg::ORIENT_TOL) begin
          turn_step = wfmc_pkg::W_ORIENT;
        end else if (bear_r < -wfmc_pkg::ORIENT_TOL) begin
          turn_step = -wfmc_pkg::W_ORIENT;
        end else begin
          mode_step = wfmc_pkg::MODE_APPROACH;
        end
      end
      wfmc_pkg::MODE_APPROACH: begin
        if (!blocked) begin
          lin_step = wfmc_pkg::V_APPROACH;
        end else begin
          mode_step = wfmc_pkg::MODE_ALIGN_START;
        end
      end
      wfmc_pkg::MODE_ALIGN_START: begin
        count_step = '0;
        mode_step  = wfmc_pkg::MODE_ALIGN;
      end
      wfmc_pkg::MODE_ALIGN, wfmc_pkg::MODE_CORNER: begin
        if (count_r < cfg.maneuver_ticks) begin
          turn_step  = (mode_r == wfmc_pkg::MODE_ALIGN) ? wfmc_pkg::W_ALIGN
                                                         : wfmc_pkg::W_CORNER;
          count_step = count_r + 1'b1;
        end else begin
          mode_step = wfmc_pkg::MODE_FOLLOW;
        end
      end
      wfmc_pkg::MODE_FOLLOW: begin
        if (q_item.goal) begin
          mode_step = wfmc_pkg::MODE_GOAL;
        end else begin
          lin_step = blocked ? '0 : wfmc_pkg::V_FOLLOW;
          if (left_r >= cfg.wall_far) begin
            turn_step = wfmc_pkg::W_TOWARD;
          end else if (left_r <= cfg.wall_near) begin
            turn_step = wfmc_pkg::W_AWAY;
          end else if (blocked) begin
            mode_step  = wfmc_pkg::MODE_CORNER;
            count_step = '0;
          end
        end
      end
      wfmc_pkg::MODE_GOAL: begin
        mode_step = mode_r;
      end
      default: begin
        mode_step = wfmc_pkg::MODE_ORIENT;
      end
    endcase
  end

  assign mode_nxt  = tick_go ? mode_step : mode_r;
  assign count_nxt = tick_go ? count_step : count_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r   <= '0;
      min_idx_r   <= '0;
      front_r     <= '0;
      left_r      <= '0;
      bear_r      <= '0;
      bidx_v_r    <= 1'b0;
      prod_v_r    <= 1'b0;
      mode_r      <= wfmc_pkg::MODE_ORIENT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_min_r   <= run_min_nxt;
      min_idx_r   <= min_idx_nxt;
      front_r     <= front_nxt;
      left_r      <= left_nxt;
      bear_r      <= bear_nxt;
      bidx_v_r    <= samp_go & q_item.is_last;
      prod_v_r    <= bidx_v_r;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bidx_r <= min_idx_nxt;
    prod_r <= bidx_r * cfg.angle_step;
    if (tick_go) begin
      out_lin_r  <= lin_step;
      out_turn_r <= turn_step;
      out_mode_r <= mode_step;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_linear_mm_s = out_lin_r;
  assign out_turn_mrad_s = out_turn_r;
  assign out_mode        = out_mode_r;

endmodule

@@ hw/rtl/wall_follow_mode_controller_core.sv @@
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-----------------------------------------
// in_      | input     | in_valid / in_ready | in_op, in_range_mm, in_goal_visible
// out_     | output    | out_valid/out_ready | out_linear_mm_s, out_turn_mrad_s, out_mode
// cfg_     | input     | cfg_we              | cfg_index, cfg_wdata
//
// one item per cycle unless a tick waits; a tick's result is registered when it is popped
// a tick right behind the last sample of a scan waits while the
//   bearing multiply and saturating add settle the minimum's bearing
// rst_n is synchronous, active low; no clearing pass, the block is ready right after reset
// samples keep draining while a result waits on out_ready; a second tick stops at the
//   queue head and the two-entry queue then fills, which drops in_ready

module wall_follow_mode_controller_core #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic [wfmc_pkg::RANGE_W-1:0]         in_range_mm,
  input  logic                                 in_goal_visible,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wfmc_pkg::LIN_W-1:0]           out_linear_mm_s,
  output logic signed [wfmc_pkg::TURN_W-1:0]   out_turn_mrad_s,
  output logic [wfmc_pkg::MODE_W-1:0]          out_mode,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [wfmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wfmc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // sample index holds 0..MAX_POINTS-1
  localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int QW    = $bits(wfmc_pkg::item_t) + IDX_W;

  wfmc_pkg::cfg_t   cfg_r;

  // front to queue
  logic             q_push, q_full;
  wfmc_pkg::item_t  f_item;
  logic [IDX_W-1:0] f_idx;

  // queue to back
  logic             q_valid, q_pop;
  logic [QW-1:0]    q_data;
  wfmc_pkg::item_t  b_item;
  logic [IDX_W-1:0] b_idx;

  // configuration regs, one at a time; user writes only while block is idle, unenforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_points    <= wfmc_pkg::RST_SCAN_POINTS;
      cfg_r.angle_start    <= wfmc_pkg::RST_ANGLE_START;
      cfg_r.angle_step     <= wfmc_pkg::RST_ANGLE_STEP;
      cfg_r.range_ceiling  <= wfmc_pkg::RST_RANGE_CEILING;
      cfg_r.front_stop     <= wfmc_pkg::RST_FRONT_STOP;
      cfg_r.wall_far       <= wfmc_pkg::RST_WALL_FAR;
      cfg_r.wall_near      <= wfmc_pkg::RST_WALL_NEAR;
      cfg_r.maneuver_ticks <= wfmc_pkg::RST_MANEUVER_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wfmc_pkg::CFG_SCAN_POINTS: begin
          cfg_r.scan_points <= cfg_wdata[wfmc_pkg::SCAN_PTS_W-1:0];
        end
        wfmc_pkg::CFG_ANGLE_START: begin
          cfg_r.angle_start <= $signed(cfg_wdata[wfmc_pkg::ANGLE_START_W-1:0]);
        end
        wfmc_pkg::CFG_ANGLE_STEP: begin
          cfg_r.angle_step <= cfg_wdata[wfmc_pkg::ANGLE_STEP_W-1:0];
        end
        wfmc_pkg::CFG_RANGE_CEILING: begin
          cfg_r.range_ceiling <= cfg_wdata[wfmc_pkg::RANGE_W-1:0];
        end
        wfmc_pkg::CFG_FRONT_STOP: begin
          cfg_r.front_stop <= cfg_wdata[wfmc_pkg::RANGE_W-1:0];
        end
        wfmc_pkg::CFG_WALL_FAR: begin
          cfg_r.wall_far <= cfg_wdata[wfmc_pkg::RANGE_W-1:0];
        end
        wfmc_pkg::CFG_WALL_NEAR: begin
          cfg_r.wall_near <= cfg_wdata[wfmc_pkg::RANGE_W-1:0];
        end
        wfmc_pkg::CFG_MANEUVER_TICKS: begin
          cfg_r.maneuver_ticks <= cfg_wdata[wfmc_pkg::TICK_W-1:0];
        end
      endcase
    end
  end

  // front: takes items, counts samples and tags first, middle and last
  wfmc_front #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_range_mm     (in_range_mm),
    .in_goal_visible (in_goal_visible),
    .scan_points     (cfg_r.scan_points),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (f_item),
    .q_idx           (f_idx)
  );

  // short in-order queue so front and back stall independently
  wfmc_fifo #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_item, f_idx}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  assign b_item = q_data[QW-1:IDX_W];
  assign b_idx  = q_data[IDX_W-1:0];

  // back: minimum tracking, bearing pipeline, mode machine and result register
  wfmc_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_item          (b_item),
    .q_idx           (b_idx),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_linear_mm_s (out_linear_mm_s),
    .out_turn_mrad_s (out_turn_mrad_s),
    .out_mode        (out_mode)
  );

endmodule

@@ hw/rtl/wfmc_checker.sv @@
`include "wall_follow_mode_controller_core_defines.svh"

module wfmc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_op,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [wfmc_pkg::LIN_W-1:0]          out_linear_mm_s,
  input logic signed [wfmc_pkg::TURN_W-1:0]  out_turn_mrad_s,
  input logic [wfmc_pkg::MODE_W-1:0]         out_mode
);

  logic [2:0] pend_r, pend_nxt;
  logic       goal_seen_r, goal_seen_nxt;
  logic       tick_in, res_out;

  assign tick_in = in_valid & in_ready & in_op;
  assign res_out = out_valid & out_ready;

  // ticks taken whose result has not yet been delivered
  always_comb begin
    pend_nxt = pend_r;
    if (tick_in && !res_out) begin
      pend_nxt = pend_r + 1'b1;
    end else if (res_out && !tick_in) begin
      pend_nxt = pend_r - 1'b1;
    end
    goal_seen_nxt = goal_seen_r | (res_out & (out_mode == wfmc_pkg::MODE_GOAL));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      goal_seen_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      goal_seen_r <= goal_seen_nxt;
    end
  end

  `WFMC_ASSERT_RESET(a_no_result_after_reset, !out_valid)
  `WFMC_ASSERT_SAME(a_result_has_tick, out_valid, pend_r != 3'd0)
  `WFMC_ASSERT_SAME(a_goal_is_final, out_valid && goal_seen_r, (out_mode == wfmc_pkg::MODE_GOAL) && (out_linear_mm_s == '0) && (out_turn_mrad_s == '0))
  `WFMC_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_mode) && $stable(out_linear_mm_s) && $stable(out_turn_mrad_s))

endmodule

bind wall_follow_mode_controller_core wfmc_checker u_wfmc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_linear_mm_s (out_linear_mm_s),
  .out_turn_mrad_s (out_turn_mrad_s),
  .out_mode        (out_mode)
);
